@@ src/i2cras_pkg.sv @@
// Shared types and codes for the I2C register access sequencer.
package i2cras_pkg;

    // Input item commands
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_RESP  = 2'd2;

    // Result queue depth (power of two, at least 2)
    localparam int FIFO_DEPTH = 4;

    // Bus primitives
    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_RESTART = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RECV    = 3'd3,
        ACT_ACK     = 3'd4,
        ACT_NACK    = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DEVACK = 3'd1,
        PH_REGACK = 3'd2,
        PH_RSACK  = 3'd3,
        PH_WDATA  = 3'd4,
        PH_TXACK  = 3'd5,
        PH_RX     = 3'd6
    } phase_t;

    // Transfer state kept between items
    typedef struct packed {
        phase_t     phase;
        logic [6:0] target_address;
        logic       direction;
        logic [7:0] remaining;
        logic [7:0] completed;
        logic [7:0] held_reg;
    } seq_state_t;

    // One result item
    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte_out;
        logic       rx_valid;
        logic       done_res;
        logic [7:0] bytes_done;
        logic       last;
    } result_t;

    // Results produced by one accepted item
    typedef struct packed {
        logic [1:0] n_res;
        result_t    res0;
        result_t    res1;
    } step_out_t;

endpackage

@@ src/i2cras_step.sv @@
// Per-item decision logic: next transfer state and up to two results.
module i2cras_step
    import i2cras_pkg::*;
(
    input  seq_state_t  state,
    input  logic        enable,
    input  logic [1:0]  cmd,
    input  logic [6:0]  device_addr,
    input  logic [7:0]  register_addr,
    input  logic        read_dir,
    input  logic [7:0]  count,
    input  logic [7:0]  tx_data,
    input  logic        acked,
    input  logic [7:0]  rx_byte,
    input  logic        timed_out,
    output seq_state_t  state_next,
    output step_out_t   step
);

    result_t blank;
    result_t stop_res;

    // Template results
    always_comb
    begin
        blank = '{action: ACT_START, tx_byte: 8'd0, rx_byte_out: 8'd0, rx_valid: 1'b0,
                  done_res: 1'b0, bytes_done: 8'd0, last: 1'b0};
        stop_res = blank;
        stop_res.action = ACT_STOP;
        stop_res.done_res = 1'b1;
        stop_res.last = 1'b1;
    end

    // Command decode and phase sequencing
    always_comb
    begin
        state_next = state;
        step.n_res = 2'd0;
        step.res0 = blank;
        step.res1 = blank;

        case (cmd)
            CMD_BEGIN:
            begin
                if (state.phase == PH_IDLE)
                begin
                    state_next.completed = 8'd0;
                    step.n_res = 2'd1;
                    step.res0.last = 1'b1;
                    if (!enable)
                    begin
                        step.res0.done_res = 1'b1;
                    end
                    else
                    begin
                        state_next.target_address = device_addr;
                        state_next.held_reg = register_addr;
                        state_next.direction = read_dir;
                        state_next.remaining = count;
                        state_next.phase = PH_DEVACK;
                        step.res0.tx_byte = {device_addr, 1'b0};
                    end
                end
            end
            CMD_DATA:
            begin
                if (state.phase == PH_WDATA)
                begin
                    state_next.phase = PH_TXACK;
                    step.n_res = 2'd1;
                    step.res0.action = ACT_SEND;
                    step.res0.tx_byte = tx_data;
                    step.res0.last = 1'b1;
                end
            end
            CMD_RESP:
            begin
                case (state.phase)
                    PH_DEVACK:
                    begin
                        step.n_res = 2'd1;
                        if (!acked)
                        begin
                            state_next.phase = PH_IDLE;
                            step.res0 = stop_res;
                        end
                        else
                        begin
                            state_next.phase = PH_REGACK;
                            step.res0.action = ACT_SEND;
                            step.res0.tx_byte = state.held_reg;
                            step.res0.last = 1'b1;
                        end
                    end
                    PH_REGACK:
                    begin
                        if (!acked || (!state.direction && state.remaining == 8'd0))
                        begin
                            state_next.phase = PH_IDLE;
                            step.n_res = 2'd1;
                            step.res0 = stop_res;
                        end
                        else if (state.direction)
                        begin
                            state_next.phase = PH_RSACK;
                            step.n_res = 2'd1;
                            step.res0.action = ACT_RESTART;
                            step.res0.tx_byte = {state.target_address, 1'b1};
                            step.res0.last = 1'b1;
                        end
                        else
                        begin
                            state_next.phase = PH_WDATA;
                        end
                    end
                    PH_RSACK:
                    begin
                        // restart acknowledge is not checked
                        step.n_res = 2'd1;
                        if (state.remaining == 8'd0)
                        begin
                            state_next.phase = PH_IDLE;
                            step.res0 = stop_res;
                        end
                        else
                        begin
                            state_next.phase = PH_RX;
                            step.res0.action = ACT_RECV;
                            step.res0.last = 1'b1;
                        end
                    end
                    PH_TXACK:
                    begin
                        if (!acked)
                        begin
                            state_next.phase = PH_IDLE;
                            step.n_res = 2'd1;
                            step.res0 = stop_res;
                        end
                        else
                        begin
                            state_next.completed = state.completed + 8'd1;
                            state_next.remaining = state.remaining - 8'd1;
                            if (state.remaining == 8'd1)
                            begin
                                state_next.phase = PH_IDLE;
                                step.n_res = 2'd1;
                                step.res0 = stop_res;
                            end
                            else
                            begin
                                state_next.phase = PH_WDATA;
                            end
                        end
                    end
                    PH_RX:
                    begin
                        step.n_res = 2'd2;
                        if (timed_out)
                        begin
                            // received byte dropped, nack then stop
                            state_next.phase = PH_IDLE;
                            step.res0.action = ACT_NACK;
                            step.res1 = stop_res;
                        end
                        else
                        begin
                            state_next.completed = state.completed + 8'd1;
                            state_next.remaining = state.remaining - 8'd1;
                            step.res0.rx_byte_out = rx_byte;
                            step.res0.rx_valid = 1'b1;
                            if (state.remaining == 8'd1)
                            begin
                                state_next.phase = PH_IDLE;
                                step.res0.action = ACT_NACK;
                                step.res1 = stop_res;
                            end
                            else
                            begin
                                step.res0.action = ACT_ACK;
                                step.res1.action = ACT_RECV;
                                step.res1.last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            default:
            begin
                state_next = state;
            end
        endcase

        // every result of an item reports the updated byte count
        step.res0.bytes_done = state_next.completed;
        step.res1.bytes_done = state_next.completed;
    end

endmodule

@@ src/i2cras_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per cycle while out_stall is low.
module i2cras_fifo
    import i2cras_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_out_t  push,
    output logic       space_low,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    // Pointer and fill bookkeeping
    always_comb
    begin
        pop = out_valid && !out_stall;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n_res);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push.n_res) - CNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign space_low = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign head = mem[rd_ptr_reg];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.n_res != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.n_res == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.res1;
        end
    end

`ifndef NO_ASSERTIONS
    // fill level never exceeds depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // occupancy agrees with the pointers
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg)))
        else $error("result queue pointers out of step with count");

    // results are only pushed when there is room for two
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n_res != 2'd0) |-> !space_low)
        else $error("result push while queue nearly full");
`endif

endmodule

@@ src/i2c_register_access_sequencer_unit.sv @@
// A result is written into the result queue when its item is accepted and is
// presented once it reaches the queue head. One item per cycle is taken while
// each item yields at most one result and in_stall stays low; the results of
// an item leave one at a time through the single read port of the four-entry queue.
// Reset (rst_n, async, active low): idle phase, enable cleared, queue empty.
// Top level of the I2C register access sequencer.
module i2c_register_access_sequencer_unit
    import i2cras_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [6:0]  device_addr,
    input  logic [7:0]  register_addr,
    input  logic        read_dir,
    input  logic [7:0]  count,
    input  logic [7:0]  tx_data,
    input  logic        acked,
    input  logic [7:0]  rx_byte,
    input  logic        timed_out,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_byte,
    output logic [7:0]  rx_byte_out,
    output logic        rx_valid,
    output logic        done_res,
    output logic [7:0]  bytes_done,
    output logic        last
);

    logic        enable_reg;
    seq_state_t  state_reg;
    seq_state_t  state_calc;
    seq_state_t  state_next;
    step_out_t   step_calc;
    step_out_t   push;
    logic        space_low;
    logic        in_accept;
    result_t     head;

    assign cfg_ready = 1'b1;
    assign in_stall = space_low;
    assign in_accept = in_valid && !space_low;

    // Per-item decision logic
    i2cras_step u_step (
        .state         (state_reg),
        .enable        (enable_reg),
        .cmd           (cmd),
        .device_addr   (device_addr),
        .register_addr (register_addr),
        .read_dir      (read_dir),
        .count         (count),
        .tx_data       (tx_data),
        .acked         (acked),
        .rx_byte       (rx_byte),
        .timed_out     (timed_out),
        .state_next    (state_calc),
        .step          (step_calc)
    );

    // Only an accepted transaction advances state or pushes results
    always_comb
    begin
        state_next = state_reg;
        push = step_calc;
        push.n_res = 2'd0;
        if (in_accept)
        begin
            state_next = state_calc;
            push.n_res = step_calc.n_res;
        end
    end

    // Transfer state and enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            state_reg <= '{phase: PH_IDLE, target_address: 7'd0, direction: 1'b0,
                           remaining: 8'd0, completed: 8'd0, held_reg: 8'd0};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
            state_reg <= state_next;
        end
    end

    // Result queue
    i2cras_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_low (space_low),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign action = head.action;
    assign tx_byte = head.tx_byte;
    assign rx_byte_out = head.rx_byte_out;
    assign rx_valid = head.rx_valid;
    assign done_res = head.done_res;
    assign bytes_done = head.bytes_done;
    assign last = head.last;

`ifndef NO_ASSERTIONS
    // a finishing result always closes its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> last)
        else $error("done result not marked last");

    // received data only rides on ack or nack
    a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rx_valid) |-> (action == ACT_ACK || action == ACT_NACK))
        else $error("received byte on wrong action");

    // enabled begin while idle moves to address acknowledge
    a_begin_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_BEGIN && state_reg.phase == PH_IDLE && enable_reg)
        |=> (state_reg.phase == PH_DEVACK))
        else $error("begin did not start addressing");

    // a stop result leaves the sequencer idle
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && step_calc.n_res != 2'd0 && step_calc.res0.action == ACT_STOP)
        |=> (state_reg.phase == PH_IDLE))
        else $error("stop issued without returning to idle");
`endif

endmodule
